>>> hdl/abd_pkg.sv
package abd_pkg;

    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned COEF_W = 32;
    localparam int unsigned PROD_W = 64;
    localparam int unsigned NDIG = COEF_W / DIGIT_W;

    localparam logic [27:0] BIAS_RESET = 28'(2030 * 65536);
    localparam logic [27:0] BIAS_MAX = 28'(4095 * 65536);
    localparam logic signed [31:0] HYST = 32'sd524288;
    localparam logic signed [47:0] MEM_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] MEM_MIN = {1'b1, {47{1'b0}}};

    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_B0 = 3'd1;
    localparam logic [2:0] REG_B1 = 3'd2;
    localparam logic [2:0] REG_B2 = 3'd3;
    localparam logic [2:0] REG_FB1 = 3'd4;
    localparam logic [2:0] REG_FB2 = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_B0,
        ST_MUL_REST,
        ST_FINISH,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        SIDE_NONE = 2'd0,
        SIDE_HIGH = 2'd1,
        SIDE_LOW = 2'd2
    } side_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } mul_ctrl_t;

endpackage

>>> hdl/abd_if.sv
interface abd_in_if;
    logic valid;
    logic ready;
    logic [11:0] adc_sample;
    modport source (output valid, output adc_sample, input ready);
    modport sink (input valid, input adc_sample, output ready);
endinterface

interface abd_out_if;
    logic valid;
    logic ready;
    logic [11:0] dac_code;
    logic clipped;
    logic [11:0] input_min;
    logic [11:0] input_max;
    logic [31:0] clip_total;
    logic [15:0] input_crossings;
    logic [15:0] output_crossings;
    logic signed [15:0] output_low;
    logic signed [15:0] output_high;
    logic [15:0] window_samples;
    logic window_done;
    modport source (output valid, output dac_code, output clipped, output input_min,
        output input_max, output clip_total, output input_crossings,
        output output_crossings, output output_low, output output_high,
        output window_samples, output window_done, input ready);
    modport sink (input valid, input dac_code, input clipped, input input_min,
        input input_max, input clip_total, input input_crossings,
        input output_crossings, input output_low, input output_high,
        input window_samples, input window_done, output ready);
endinterface

>>> hdl/abd_serial_mul.sv
module abd_serial_mul
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  abd_pkg::mul_ctrl_t    ctrl_in,
    output abd_pkg::mul_ctrl_t    ctrl_out,
    input  logic signed [31:0]    coef,
    input  logic signed [31:0]    operand,
    output logic signed [35:0]    rounded
);

    localparam int unsigned CNT_W = $clog2(abd_pkg::NDIG + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0] digits_reg, digits_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [31:0] op_reg, op_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic signed [36:0] part;
    logic last;

    // the top digit of the coefficient carries negative weight
    assign last = (cnt_reg == CNT_W'(abd_pkg::NDIG - 1));

    always_comb
    begin
        if (last)
            part = op_reg * $signed(digits_reg[3:0]);
        else
            part = op_reg * $signed({1'b0, digits_reg[3:0]});
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        digits_next = digits_reg;
        acc_next = acc_reg;
        op_next = op_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl_in.start)
        begin
            cnt_next = '0;
            digits_next = coef;
            op_next = operand;
            acc_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + (64'(part) <<< (cnt_reg * abd_pkg::DIGIT_W));
            digits_next = digits_reg >> abd_pkg::DIGIT_W;
            cnt_next = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        acc_reg <= acc_next;
        op_reg <= op_next;
    end

    logic signed [63:0] acc_round;
    assign acc_round = acc_reg + 64'sd134217728;
    assign rounded = acc_round[63:28];

    assign ctrl_out.start = 1'b0;
    assign ctrl_out.busy = busy_reg;
    assign ctrl_out.done = done_reg;

    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy_reg)
        else $error("multiplier done while busy");
    assert property (@(posedge clk) disable iff (!rst_n) ctrl_in.start |=> busy_reg)
        else $error("multiplier failed to start");
    assert property (@(posedge clk) disable iff (!rst_n) $fell(busy_reg) |-> done_reg)
        else $error("multiplier stopped without done");

endmodule

>>> hdl/adc_biquad_dac_stream.sv
// an accepted item runs through five multiplies (b0, b1, b2, fb1, fb2), then ST_FINISH registers its result
// items are taken one at a time: a new item waits until the shared 4-bit digit-serial multiplier is done
// passthrough mode also runs the multiplies, so the timing does not depend on mode
// reset: asynchronous active low; bias 2030.0, filter memories zero, coefficients b0 = 1.0
// output register holds a result until taken; no new item is accepted meanwhile
module adc_biquad_dac_stream
#(
    parameter int unsigned BLOCK_SAMPLES = 512,
    parameter int unsigned WINDOW_FIRST_BLOCK = 4,
    parameter int unsigned WINDOW_END_BLOCK = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    abd_in_if.sink      in_ch,
    abd_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned POS_W = $clog2(BLOCK_SAMPLES + 1);
    localparam int unsigned WC_W = $clog2(WINDOW_END_BLOCK + 1);

    abd_pkg::state_t state_reg, state_next;
    logic mode_reg;
    logic signed [31:0] coef_reg [5];
    logic [2:0] midx_reg, midx_next;
    logic [27:0] bias_reg;
    logic signed [47:0] m1_reg, m2_reg;
    logic signed [31:0] x_reg, y_reg;
    logic signed [47:0] acc1_reg, acc2_reg;
    logic [11:0] inmin_reg, inmax_reg;
    logic [31:0] clipcnt_reg;
    abd_pkg::side_t iside_reg, oside_reg;
    logic [15:0] icross_reg, ocross_reg;
    logic signed [15:0] omin_reg, omax_reg;
    logic [POS_W-1:0] pos_reg;
    logic [WC_W-1:0] wc_reg;
    logic [11:0] code_reg;
    logic clip_reg;
    logic [15:0] ws_reg;
    logic valid_reg;
    logic started_reg;

    abd_pkg::mul_ctrl_t mctl_in, mctl_out;
    logic signed [31:0] mul_coef, mul_op;
    logic signed [35:0] mul_res;

    logic wr;
    logic [2:0] widx;
    assign wr = psel && penable && pwrite;
    assign widx = paddr[4:2];
    assign pready = 1'b1;

    always_comb
    begin
        case (widx)
            abd_pkg::REG_MODE: prdata = {31'd0, mode_reg};
            abd_pkg::REG_B0: prdata = coef_reg[0];
            abd_pkg::REG_B1: prdata = coef_reg[1];
            abd_pkg::REG_B2: prdata = coef_reg[2];
            abd_pkg::REG_FB1: prdata = coef_reg[3];
            abd_pkg::REG_FB2: prdata = coef_reg[4];
            default: prdata = '0;
        endcase
    end

    // x, then the b0 product gives y; the remaining four use x or y
    logic signed [31:0] x_now;
    assign x_now = $signed({4'd0, in_ch.adc_sample, 16'd0}) - $signed({4'd0, bias_reg});

    logic accept;
    assign accept = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == abd_pkg::ST_IDLE) && !valid_reg;

    always_comb
    begin
        mul_coef = coef_reg[midx_reg];
        mul_op = (midx_reg == 3'd3 || midx_reg == 3'd4) ? y_reg : x_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            abd_pkg::ST_IDLE: if (accept) state_next = abd_pkg::ST_MUL_B0;
            abd_pkg::ST_MUL_B0: if (mctl_out.done) state_next = abd_pkg::ST_MUL_REST;
            abd_pkg::ST_MUL_REST:
                if (mctl_out.done && midx_reg == 3'd4) state_next = abd_pkg::ST_FINISH;
            abd_pkg::ST_FINISH: state_next = abd_pkg::ST_OUT;
            abd_pkg::ST_OUT: state_next = abd_pkg::ST_IDLE;
            default: state_next = abd_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        midx_next = midx_reg;
        mctl_in = '0;
        case (state_reg)
            abd_pkg::ST_IDLE:
            begin
                midx_next = 3'd0;
            end
            abd_pkg::ST_MUL_B0:
            begin
                mctl_in.start = !mctl_out.busy && !mctl_out.done && midx_reg == 3'd0
                    && !started_reg;
                if (mctl_out.done) midx_next = 3'd1;
            end
            abd_pkg::ST_MUL_REST:
            begin
                mctl_in.start = !mctl_out.busy && !mctl_out.done && !started_reg;
                if (mctl_out.done && midx_reg != 3'd4) midx_next = midx_reg + 3'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            started_reg <= 1'b0;
        else if (mctl_in.start)
            started_reg <= 1'b1;
        else if (mctl_out.done)
            started_reg <= 1'b0;
    end

    abd_serial_mul u_mul
    (
        .clk(clk), .rst_n(rst_n), .ctrl_in(mctl_in), .ctrl_out(mctl_out),
        .coef(mul_coef), .operand(mul_op), .rounded(mul_res)
    );

    localparam logic signed [49:0] MEM_MAX_C = {3'b000, {47{1'b1}}};
    function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
        if (v > MEM_MAX_C) return abd_pkg::MEM_MAX;
        else if (v < -MEM_MAX_C - 50'sd1) return abd_pkg::MEM_MIN;
        else return v[47:0];
    endfunction

    logic signed [48:0] ysum;
    logic signed [31:0] ysat;
    assign ysum = 49'(mul_res) + 49'(m1_reg);
    assign ysat = (ysum > 49'sd2147483647) ? 32'sh7fffffff :
                  (ysum < -49'sd2147483648) ? 32'sh80000000 : ysum[31:0];

    logic signed [32:0] y_fin;
    logic signed [32:0] vout;
    logic signed [16:0] yc_raw;
    logic signed [15:0] yc;
    logic in_win;
    logic [11:0] code_c;
    logic clip_c;
    logic [POS_W-1:0] pos_n;
    logic [WC_W-1:0] wc_n;
    logic [31:0] ws_c;
    abd_pkg::side_t iside_n, oside_n;
    logic [15:0] icross_n, ocross_n;
    logic signed [32:0] yr;

    always_comb
    begin
        y_fin = mode_reg ? 33'(y_reg) : 33'(x_reg);
        in_win = (32'(wc_reg) >= WINDOW_FIRST_BLOCK) && (32'(wc_reg) < WINDOW_END_BLOCK);
        yr = (y_fin + 33'sd32768) >>> 16;
        yc_raw = yr[16:0];
        yc = (yr > 33'sd32767) ? 16'sh7fff : (yr < -33'sd32768) ? 16'sh8000 : yc_raw[15:0];
        iside_n = iside_reg; icross_n = icross_reg;
        if (x_reg >= abd_pkg::HYST)
        begin
            if (iside_reg == abd_pkg::SIDE_LOW && icross_reg != 16'hffff)
                icross_n = icross_reg + 16'd1;
            iside_n = abd_pkg::SIDE_HIGH;
        end
        else if (x_reg <= -abd_pkg::HYST) iside_n = abd_pkg::SIDE_LOW;
        oside_n = oside_reg; ocross_n = ocross_reg;
        if (y_fin >= 33'(abd_pkg::HYST))
        begin
            if (oside_reg == abd_pkg::SIDE_LOW && ocross_reg != 16'hffff)
                ocross_n = ocross_reg + 16'd1;
            oside_n = abd_pkg::SIDE_HIGH;
        end
        else if (y_fin <= -33'(abd_pkg::HYST)) oside_n = abd_pkg::SIDE_LOW;
        vout = y_fin + 33'sd134217728;
        clip_c = 1'b0;
        if (vout < 0) begin code_c = 12'd0; clip_c = 1'b1; end
        else if (vout > 33'sd268369920) begin code_c = 12'd4095; clip_c = 1'b1; end
        else code_c = 12'((vout + 33'sd32768) >>> 16);
        pos_n = pos_reg; wc_n = wc_reg;
        if (32'(wc_reg) < WINDOW_END_BLOCK)
        begin
            if (32'(pos_reg) + 1 >= BLOCK_SAMPLES)
            begin
                pos_n = '0;
                wc_n = wc_reg + 1'b1;
            end
            else pos_n = pos_reg + 1'b1;
        end
        if (WINDOW_FIRST_BLOCK >= WINDOW_END_BLOCK || 32'(wc_n) < WINDOW_FIRST_BLOCK)
            ws_c = '0;
        else
            ws_c = (32'(wc_n) - WINDOW_FIRST_BLOCK) * BLOCK_SAMPLES + 32'(pos_n);
    end

    logic [27:0] bias_c;
    logic signed [32:0] bsum;
    assign bsum = 33'(bias_reg) + 33'((33'(x_now) + 33'sd32768) >>> 16);
    assign bias_c = (bsum < 0) ? 28'd0 : (bsum > 33'(abd_pkg::BIAS_MAX)) ?
        abd_pkg::BIAS_MAX : bsum[27:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= abd_pkg::ST_IDLE;
            midx_reg <= '0;
            mode_reg <= 1'b0;
            coef_reg[0] <= 32'sd268435456;
            coef_reg[1] <= '0; coef_reg[2] <= '0; coef_reg[3] <= '0; coef_reg[4] <= '0;
            bias_reg <= abd_pkg::BIAS_RESET;
            m1_reg <= '0; m2_reg <= '0;
            inmin_reg <= 12'd4095; inmax_reg <= '0;
            clipcnt_reg <= '0;
            iside_reg <= abd_pkg::SIDE_NONE; oside_reg <= abd_pkg::SIDE_NONE;
            icross_reg <= '0; ocross_reg <= '0;
            omin_reg <= 16'sd4095; omax_reg <= -16'sd4095;
            pos_reg <= '0; wc_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            midx_reg <= midx_next;
            if (valid_reg && out_ch.ready) valid_reg <= 1'b0;
            if (wr && pready)
            begin
                if (widx == abd_pkg::REG_MODE) mode_reg <= pwdata[0];
                else if (widx <= abd_pkg::REG_FB2)
                begin
                    coef_reg[widx - 3'd1] <= pwdata;
                    m1_reg <= '0; m2_reg <= '0;
                end
            end
            if (accept)
            begin
                bias_reg <= bias_c;
                if (in_ch.adc_sample < inmin_reg) inmin_reg <= in_ch.adc_sample;
                if (in_ch.adc_sample > inmax_reg) inmax_reg <= in_ch.adc_sample;
            end
            if (state_reg == abd_pkg::ST_FINISH && mode_reg)
            begin
                m1_reg <= sat48(50'(acc1_reg) + 50'(m2_reg));
                m2_reg <= acc2_reg;
            end
            if (state_reg == abd_pkg::ST_FINISH)
            begin
                if (in_win)
                begin
                    iside_reg <= iside_n; icross_reg <= icross_n;
                    oside_reg <= oside_n; ocross_reg <= ocross_n;
                    if (yc < omin_reg) omin_reg <= yc;
                    if (yc > omax_reg) omax_reg <= yc;
                end
                if (clip_c && clipcnt_reg != 32'hffffffff) clipcnt_reg <= clipcnt_reg + 32'd1;
                pos_reg <= pos_n; wc_reg <= wc_n;
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            x_reg <= x_now;
        if (mctl_out.done)
        begin
            case (midx_reg)
                3'd0: y_reg <= ysat;
                3'd1: acc1_reg <= 48'(mul_res);
                3'd2: acc2_reg <= 48'(mul_res);
                3'd3: acc1_reg <= sat48(50'(acc1_reg) + 50'(mul_res));
                3'd4: acc2_reg <= sat48(50'(acc2_reg) + 50'(mul_res));
                default: ;
            endcase
        end
        if (state_reg == abd_pkg::ST_FINISH)
        begin
            code_reg <= code_c;
            clip_reg <= clip_c;
            ws_reg <= (ws_c > 32'd65535) ? 16'hffff : ws_c[15:0];
        end
    end

    assign out_ch.valid = valid_reg;
    assign out_ch.dac_code = code_reg;
    assign out_ch.clipped = clip_reg;
    assign out_ch.input_min = inmin_reg;
    assign out_ch.input_max = inmax_reg;
    assign out_ch.clip_total = clipcnt_reg;
    assign out_ch.input_crossings = icross_reg;
    assign out_ch.output_crossings = ocross_reg;
    assign out_ch.output_low = omin_reg;
    assign out_ch.output_high = omax_reg;
    assign out_ch.window_samples = ws_reg;
    assign out_ch.window_done = (32'(wc_reg) >= WINDOW_END_BLOCK);

    assert property (@(posedge clk) disable iff (!rst_n) accept |=> !in_ch.ready)
        else $error("item accepted while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == abd_pkg::ST_FINISH) |=> valid_reg)
        else $error("result lost");
    assert property (@(posedge clk) disable iff (!rst_n) valid_reg |-> !in_ch.ready)
        else $error("ready while result pending");

endmodule
